[rtl/assert_macros.svh]
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under active-low reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication under active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[rtl/sgma_pkg.sv]
// package: types, constants and the arctangent table of the sobel gradient block
package sgma_pkg;

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [10:0] FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [10:0] FRAME_HEIGHT_RESET = 11'd480;

    // cordic and fixed-point geometry
    localparam int CORDIC_STEPS = 48;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int AQ           = 56;
    localparam int XSCALE       = 40;
    localparam int XW           = 54;
    localparam int TW           = 60;
    localparam int OUT_SHIFT    = AQ - 12;

    typedef logic [CORDIC_STEPS-1:0][63:0] t_atab;

    // restoring long division of a non-negative numerator
    function automatic longint div_pos(longint num, longint den);
        longint q;
        longint rem;
        int     b;
        q   = 0;
        rem = 0;
        for (b = 62; b >= 0; b--) begin
            rem = (rem <<< 1) | ((num >>> b) & longint'(1));
            if (rem >= den) begin
                rem = rem - den;
                q   = q | (longint'(1) <<< b);
            end
        end
        return q;
    endfunction

    // arctangent table in Q56, entry 0 is pi/4 by Machin's formula
    function automatic t_atab build_atab();
        t_atab  tab;
        longint p;
        longint s;
        longint t;
        longint a5;
        longint a239;
        int     i;
        int     k;
        int     sh;
        // arctan(1/5)
        p = (longint'(1) << AQ) / 5;
        s = 0;
        i = 0;
        while (p != 0) begin
            t = div_pos(p, longint'(2 * i + 1));
            s = (i % 2 == 1) ? s - t : s + t;
            p = p / 25;
            i++;
        end
        a5 = s;
        // arctan(1/239)
        p = (longint'(1) << AQ) / 239;
        s = 0;
        i = 0;
        while (p != 0) begin
            t = div_pos(p, longint'(2 * i + 1));
            s = (i % 2 == 1) ? s - t : s + t;
            p = p / 57121;
            i++;
        end
        a239 = s;
        tab[0] = 64'(4 * a5 - a239);
        // arctan(2^-k) by series
        for (k = 1; k < CORDIC_STEPS; k++) begin
            p  = longint'(1) << (AQ - k);
            s  = 0;
            i  = 0;
            sh = 2 * k;
            while (p != 0) begin
                t = div_pos(p, longint'(2 * i + 1));
                s = (i % 2 == 1) ? s - t : s + t;
                if (sh >= 63) begin
                    p = 0;
                end else begin
                    p = p >>> sh;
                end
                i++;
            end
            tab[k] = 64'(s);
        end
        return tab;
    endfunction

    localparam t_atab ATAB = build_atab();

    // commands from controller to datapath
    typedef struct packed {
        logic              accept;
        logic              shift;
        logic              load;
        logic              r2;
        logic              c2;
        logic              top_edge;
        logic              left_edge;
        logic              last;
        logic [9:0]        row;
        logic [9:0]        col;
        logic              square;
        logic              init;
        logic              iter;
        logic [STEP_W-1:0] step;
        logic              finish;
    } t_dp_cmd;

endpackage

[rtl/sgma_ram.sv]
// generic single-port-write ram with registered read
module sgma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

[rtl/sgma_datapath.sv]
// datapath: line stores, 3x3 window, sobel sums, iterative square root and cordic
module sgma_datapath #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sgma_pkg::t_dp_cmd            i_cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_col_addr,
    input  logic [7:0]                   i_pixel_value,
    output logic [9:0]                   o_out_row,
    output logic [9:0]                   o_out_col,
    output logic signed [10:0]           o_grad_x,
    output logic signed [10:0]           o_grad_y,
    output logic [10:0]                  o_grad_magnitude,
    output logic signed [14:0]           o_grad_angle,
    output logic                         o_last_of_run
);
    import sgma_pkg::*;

    logic [7:0]             r_pixel;
    logic [15:0]            ram_rdata;
    logic [7:0]             r_win [3][3];
    logic [1:0]             sel_top;
    logic [1:0]             sel_mid;
    logic [1:0]             sel_lef;
    logic [1:0]             sel_cm;
    logic signed [11:0]     gx12;
    logic signed [11:0]     gy12;
    logic signed [10:0]     r_gx;
    logic signed [10:0]     r_gy;
    logic [9:0]             r_row;
    logic [9:0]             r_col;
    logic                   r_last;
    logic signed [21:0]     sq_x;
    logic signed [21:0]     sq_y;
    logic [19:0]            r_sqx;
    logic [19:0]            r_sqy;
    logic [9:0]             ax;
    logic [9:0]             ay;
    logic                   r_ax0;
    logic                   r_ay0;
    logic [20:0]            r_rem;
    logic [20:0]            r_res;
    logic [20:0]            r_bit;
    logic [20:0]            trial;
    logic signed [XW-1:0]   r_x;
    logic signed [XW-1:0]   r_y;
    logic signed [TW-1:0]   r_th;
    logic signed [XW-1:0]   xs;
    logic signed [XW-1:0]   ys;
    logic [XW-1:0]          y_mag;
    logic signed [TW-1:0]   step_ang;
    logic signed [TW-1:0]   a0;
    logic signed [TW-1:0]   th_q;
    logic signed [TW-1:0]   th_h;
    logic signed [TW-1:0]   th_r;
    logic signed [14:0]     ang_abs;

    function automatic logic signed [11:0] z12(input logic [7:0] v);
        return $signed({4'b0000, v});
    endfunction

    // line stores: upper byte holds the older row
    sgma_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.shift),
        .i_wr_addr (i_col_addr),
        .i_wr_data ({ram_rdata[7:0], r_pixel}),
        .i_rd_en   (i_cmd.accept),
        .i_rd_addr (i_col_addr),
        .o_rd_data (ram_rdata)
    );

    // pixel capture on input transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pixel <= i_pixel_value;
        end
    end

    // window shift: column 2 is the newest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= 8'd0;
                end
            end
        end else if (i_cmd.shift) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= ram_rdata[15:8];
            r_win[1][2] <= ram_rdata[7:0];
            r_win[2][2] <= r_pixel;
        end
    end

    // tap selection with edge replication
    always_comb begin
        sel_top = (i_cmd.r2 || i_cmd.top_edge) ? 2'd1 : 2'd0;
        sel_mid = i_cmd.r2 ? 2'd2 : 2'd1;
        sel_lef = (i_cmd.c2 || i_cmd.left_edge) ? 2'd1 : 2'd0;
        sel_cm  = i_cmd.c2 ? 2'd2 : 2'd1;
    end

    // sobel sums
    always_comb begin
        gx12 = z12(r_win[sel_top][2]) + z12(r_win[sel_mid][2]) + z12(r_win[sel_mid][2])
             + z12(r_win[2][2])
             - z12(r_win[sel_top][sel_lef]) - z12(r_win[sel_mid][sel_lef])
             - z12(r_win[sel_mid][sel_lef]) - z12(r_win[2][sel_lef]);
        gy12 = z12(r_win[2][sel_lef]) + z12(r_win[2][sel_cm]) + z12(r_win[2][sel_cm])
             + z12(r_win[2][2])
             - z12(r_win[sel_top][sel_lef]) - z12(r_win[sel_top][sel_cm])
             - z12(r_win[sel_top][sel_cm]) - z12(r_win[sel_top][2]);
    end

    // absolute values and squares
    always_comb begin
        ax   = r_gx[10] ? 10'(-r_gx) : 10'(r_gx);
        ay   = r_gy[10] ? 10'(-r_gy) : 10'(r_gy);
        sq_x = r_gx * r_gx;
        sq_y = r_gy * r_gy;
    end

    // cordic step terms, y shifted toward zero
    always_comb begin
        y_mag    = r_y[XW-1] ? XW'(-r_y) : XW'(r_y);
        xs       = r_x >>> i_cmd.step;
        ys       = r_y[XW-1] ? -$signed(y_mag >> i_cmd.step) : $signed(y_mag >> i_cmd.step);
        step_ang = TW'($signed(ATAB[i_cmd.step]));
        trial    = r_res + r_bit;
    end

    // operand registers and iterations
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_gx   <= 11'(gx12);
            r_gy   <= 11'(gy12);
            r_row  <= i_cmd.row;
            r_col  <= i_cmd.col;
            r_last <= i_cmd.last;
        end
        if (i_cmd.square) begin
            r_sqx <= 20'(sq_x);
            r_sqy <= 20'(sq_y);
            r_ax0 <= (ax == 10'd0);
            r_ay0 <= (ay == 10'd0);
            r_x   <= $signed(XW'(ax) << XSCALE);
            r_y   <= $signed(XW'(ay) << XSCALE);
        end
        if (i_cmd.init) begin
            r_rem <= 21'(r_sqx) + 21'(r_sqy);
            r_res <= 21'd0;
            r_bit <= 21'd1 << 20;
            r_th  <= '0;
        end
        if (i_cmd.iter) begin
            // square root digit while bits remain
            if (r_bit != 21'd0) begin
                if (r_rem >= trial) begin
                    r_rem <= r_rem - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            // vectoring rotation
            if (!r_y[XW-1]) begin
                r_x  <= r_x + ys;
                r_y  <= r_y - xs;
                r_th <= r_th + step_ang;
            end else begin
                r_x  <= r_x - ys;
                r_y  <= r_y + xs;
                r_th <= r_th - step_ang;
            end
        end
    end

    // quadrant fix-up and rounding to q12
    always_comb begin
        a0      = TW'($signed(ATAB[0]));
        th_q    = r_ay0 ? '0 : (r_ax0 ? (a0 <<< 1) : r_th);
        th_h    = r_gx[10] ? ((a0 <<< 2) - th_q) : th_q;
        th_r    = (th_h + (TW'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        ang_abs = 15'(th_r);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_out_row        <= r_row;
            o_out_col        <= r_col;
            o_grad_x         <= r_gx;
            o_grad_y         <= r_gy;
            o_grad_magnitude <= 11'(r_res);
            o_grad_angle     <= r_gy[10] ? -ang_abs : ang_abs;
            o_last_of_run    <= r_last;
        end
    end
endmodule

[rtl/sgma_ctrl.sv]
// controller: frame counters, configuration, result sequencing and output handshake
module sgma_ctrl #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic                         i_cfg_index,
    input  logic [10:0]                  i_cfg_data,
    input  logic                         i_pixel_valid,
    output logic                         o_pixel_stall,
    output logic                         o_result_valid,
    input  logic                         i_result_stall,
    output sgma_pkg::t_dp_cmd            o_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0] o_col_addr
);
    import sgma_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_SEL  = 7'b0000100,
        S_SQ   = 7'b0001000,
        S_INIT = 7'b0010000,
        S_ITER = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [10:0]       r_frame_width, n_frame_width;
    logic [10:0]       r_frame_height, n_frame_height;
    logic [CW-1:0]     r_col, n_col;
    logic [RW-1:0]     r_row, n_row;
    logic [CW-1:0]     r_cur_c, n_cur_c;
    logic [RW-1:0]     r_cur_r, n_cur_r;
    logic [3:0]        r_mask, n_mask;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic [CW-1:0]     w_last;
    logic [RW-1:0]     h_last;
    logic [CW-1:0]     cur_c;
    logic [RW-1:0]     cur_r;
    logic [3:0]        pick;
    logic [RW-1:0]     sel_row;
    logic [CW-1:0]     sel_col;
    t_dp_cmd           cmd;

    // clamp frame size to the supported range
    always_comb begin
        if (r_frame_width < 11'd2) begin
            w_last = CW'(1);
        end else if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(r_frame_width - 11'd1);
        end
        if (r_frame_height < 11'd2) begin
            h_last = RW'(1);
        end else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(r_frame_height - 11'd1);
        end
    end

    // position of the incoming pixel, restarted if outside the frame
    always_comb begin
        if (r_col > w_last || r_row > h_last) begin
            cur_c = '0;
            cur_r = '0;
        end else begin
            cur_c = r_col;
            cur_r = r_row;
        end
    end

    // lowest pending result first
    always_comb begin
        pick = 4'b0000;
        if (r_mask[0]) begin
            pick = 4'b0001;
        end else if (r_mask[1]) begin
            pick = 4'b0010;
        end else if (r_mask[2]) begin
            pick = 4'b0100;
        end else if (r_mask[3]) begin
            pick = 4'b1000;
        end
        sel_row = (pick[0] || pick[1]) ? r_cur_r - RW'(1) : r_cur_r;
        sel_col = (pick[0] || pick[2]) ? r_cur_c - CW'(1) : r_cur_c;
    end

    // next-state and command logic
    always_comb begin
        n_state        = r_state;
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        n_col          = r_col;
        n_row          = r_row;
        n_cur_c        = r_cur_c;
        n_cur_r        = r_cur_r;
        n_mask         = r_mask;
        n_step         = r_step;
        cmd            = '0;
        cmd.step       = r_step;
        cmd.row        = 10'(sel_row);
        cmd.col        = 10'(sel_col);
        cmd.r2         = pick[2] || pick[3];
        cmd.c2         = pick[1] || pick[3];
        cmd.top_edge   = (sel_row == '0);
        cmd.left_edge  = (sel_col == '0);
        cmd.last       = ((r_mask & ~pick) == 4'b0000);
        case (r_state)
            S_IDLE: begin
                if (i_pixel_valid) begin
                    cmd.accept = 1'b1;
                    n_cur_c    = cur_c;
                    n_cur_r    = cur_r;
                    n_mask     = {(cur_r == h_last) && (cur_c == w_last),
                                  (cur_r == h_last) && (cur_c != '0),
                                  (cur_r != '0) && (cur_c == w_last),
                                  (cur_r != '0) && (cur_c != '0)};
                    if (cur_c == w_last) begin
                        n_col = '0;
                        n_row = (cur_r == h_last) ? '0 : cur_r + RW'(1);
                    end else begin
                        n_col = cur_c + CW'(1);
                        n_row = cur_r;
                    end
                    n_state = S_READ;
                end
            end
            S_READ: begin
                cmd.shift = 1'b1;
                n_state   = S_SEL;
            end
            S_SEL: begin
                if (r_mask == 4'b0000) begin
                    n_state = S_IDLE;
                end else begin
                    cmd.load = 1'b1;
                    n_mask   = r_mask & ~pick;
                    n_state  = S_SQ;
                end
            end
            S_SQ: begin
                cmd.square = 1'b1;
                n_state    = S_INIT;
            end
            S_INIT: begin
                cmd.init = 1'b1;
                n_step   = '0;
                n_state  = S_ITER;
            end
            S_ITER: begin
                cmd.iter = 1'b1;
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_FIN;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_result_stall) begin
                    cmd.finish = 1'b1;
                    n_state    = S_SEL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // configuration write restarts the frame
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    n_frame_width = i_cfg_data;
                end
                CFG_FRAME_HEIGHT: begin
                    n_frame_height = i_cfg_data;
                end
                default: begin
                    n_frame_width = r_frame_width;
                end
            endcase
            n_col = '0;
            n_row = '0;
        end
    end

    // output valid: set on finish, cleared on transfer
    always_comb begin
        if (cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_result_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_frame_width  <= FRAME_WIDTH_RESET;
            r_frame_height <= FRAME_HEIGHT_RESET;
            r_col          <= '0;
            r_row          <= '0;
            r_mask         <= 4'b0000;
            r_step         <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
            r_col          <= n_col;
            r_row          <= n_row;
            r_mask         <= n_mask;
            r_step         <= n_step;
            r_out_valid    <= n_out_valid;
        end
    end

    // position of the pixel in work
    always_ff @(posedge i_clk) begin
        r_cur_c <= n_cur_c;
        r_cur_r <= n_cur_r;
    end

    assign o_cmd          = cmd;
    assign o_col_addr     = (r_state == S_IDLE) ? cur_c : r_cur_c;
    assign o_pixel_stall  = (r_state != S_IDLE);
    assign o_result_valid = r_out_valid;
endmodule

[rtl/sobel_gradient_magnitude_angle.sv]
// Streaming 3x3 Sobel gradient with magnitude and direction for raster pixel
// frames. One pixel is taken at a time: a pixel that yields no result goes
// through the transfer, the line store read and the window shift; each result
// it yields adds the operand load, squaring, setup, 48 CORDIC iterations and
// the output load, one result at a time on the single shared CORDIC unit whose
// iterations also carry the square root digits. The output load of a result
// waits for the output register to free up. The next pixel can be transferred
// while the last result still waits downstream. Writing either frame size
// register restarts the frame at row 0, column 0. The line stores need no
// clearing after reset.
module sobel_gradient_magnitude_angle #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_index,
    input  logic [10:0]        i_cfg_data,
    input  logic               i_pixel_valid,
    output logic               o_pixel_stall,
    input  logic [7:0]         i_pixel_value,
    output logic               o_result_valid,
    input  logic               i_result_stall,
    output logic [9:0]         o_out_row,
    output logic [9:0]         o_out_col,
    output logic signed [10:0] o_grad_x,
    output logic signed [10:0] o_grad_y,
    output logic [10:0]        o_grad_magnitude,
    output logic signed [14:0] o_grad_angle,
    output logic               o_last_of_run
);
    import sgma_pkg::*;

    t_dp_cmd                      cmd;
    logic [$clog2(MAX_WIDTH)-1:0] col_addr;

    // sequencing
    sgma_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_pixel_valid  (i_pixel_valid),
        .o_pixel_stall  (o_pixel_stall),
        .o_result_valid (o_result_valid),
        .i_result_stall (i_result_stall),
        .o_cmd          (cmd),
        .o_col_addr     (col_addr)
    );

    // arithmetic and storage
    sgma_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_col_addr       (col_addr),
        .i_pixel_value    (i_pixel_value),
        .o_out_row        (o_out_row),
        .o_out_col        (o_out_col),
        .o_grad_x         (o_grad_x),
        .o_grad_y         (o_grad_y),
        .o_grad_magnitude (o_grad_magnitude),
        .o_grad_angle     (o_grad_angle),
        .o_last_of_run    (o_last_of_run)
    );
endmodule

[rtl/sgma_checker.sv]
// port-level checks for the sobel gradient block, bound to the top level
`include "assert_macros.svh"

module sgma_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_wr_en,
    input logic               i_cfg_index,
    input logic [10:0]        i_cfg_data,
    input logic               i_pixel_valid,
    input logic               o_pixel_stall,
    input logic [7:0]         i_pixel_value,
    input logic               o_result_valid,
    input logic               i_result_stall,
    input logic [9:0]         o_out_row,
    input logic [9:0]         o_out_col,
    input logic signed [10:0] o_grad_x,
    input logic signed [10:0] o_grad_y,
    input logic [10:0]        o_grad_magnitude,
    input logic signed [14:0] o_grad_angle,
    input logic               o_last_of_run
);
    // a pixel transfer keeps the input side busy for the next cycle
    `ASSERT_NEXT(a_busy_after_pixel, i_clk, i_rst_n, i_pixel_valid && !o_pixel_stall, o_pixel_stall)

    // while a non-final result waits, the run is not over
    `ASSERT_SAME(a_run_busy, i_clk, i_rst_n, o_result_valid && !o_last_of_run, o_pixel_stall)

    // zero magnitude exactly when both sums are zero
    `ASSERT_SAME(a_mag_zero, i_clk, i_rst_n, o_result_valid, (o_grad_magnitude == 11'd0) == ((o_grad_x == 11'sd0) && (o_grad_y == 11'sd0)))

    // a stalled result holds its valid
    `ASSERT_NEXT(a_valid_hold, i_clk, i_rst_n, o_result_valid && i_result_stall, o_result_valid)
endmodule

bind sobel_gradient_magnitude_angle sgma_checker u_sgma_checker (.*);

[test/tb_sobel_gradient_magnitude_angle.sv]
// self-checking testbench of the sobel gradient block: table of frames, then random frames
module tb_sobel_gradient_magnitude_angle;
    timeunit 1ns;
    timeprecision 1ps;

    import sgma_pkg::*;

    localparam int MAXW = 1024;
    localparam int MAXH = 1024;
    localparam int STALL_PCT = 38;
    localparam int SETTLE = 120;
    localparam int WATCHDOG = 6000;
    localparam int RANDOM_PIXELS = 150;

    typedef struct packed {
        logic [9:0]         row;
        logic [9:0]         col;
        logic signed [10:0] gx;
        logic signed [10:0] gy;
        logic [10:0]        mag;
        logic signed [14:0] ang;
        logic               last;
    } t_grad;

    // gradient values typed in for frames whose result is obvious
    typedef struct {
        logic [7:0] pix;
        bit         known;
        int         gx;
        int         gy;
        int         mag;
        int         ang;
    } t_pixel_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic               i_cfg_index = CFG_FRAME_WIDTH;
    logic [10:0]        i_cfg_data = '0;
    logic               i_pixel_valid = 1'b0;
    logic               o_pixel_stall;
    logic [7:0]         i_pixel_value = '0;
    logic               o_result_valid;
    logic               i_result_stall = 1'b0;
    logic [9:0]         o_out_row;
    logic [9:0]         o_out_col;
    logic signed [10:0] o_grad_x;
    logic signed [10:0] o_grad_y;
    logic [10:0]        o_grad_magnitude;
    logic signed [14:0] o_grad_angle;
    logic               o_last_of_run;

    sobel_gradient_magnitude_angle dut (.*);

    always #1 i_clk = ~i_clk;

    // predictor state
    longint      arc_tab[48];
    logic [7:0]  store_up[MAXW];
    logic [7:0]  store_lo[MAXW];
    logic [7:0]  win[3][3];
    int          row_pos;
    int          col_pos;
    logic [10:0] width_reg;
    logic [10:0] height_reg;

    t_grad       grad_q[$];
    t_pixel_row  typed_q[$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    bit          no_idle = 0;
    int          hold_left = 0;

    function automatic longint arc_recip(longint n);
        longint p;
        longint s;
        longint i;
        p = (longint'(1) << 56) / n;
        s = 0;
        i = 0;
        while (p != 0) begin
            s = (i % 2 == 1) ? s - p / (2 * i + 1) : s + p / (2 * i + 1);
            p = p / (n * n);
            i++;
        end
        return s;
    endfunction

    function automatic longint arc_pow2(int k);
        longint p;
        longint s;
        longint i;
        p = longint'(1) << (56 - k);
        s = 0;
        i = 0;
        while (p != 0) begin
            s = (i % 2 == 1) ? s - p / (2 * i + 1) : s + p / (2 * i + 1);
            if (2 * k >= 63) break;
            p = p >>> (2 * k);
            i++;
        end
        return s;
    endfunction

    function automatic longint shr_sym(longint v, int k);
        return v >= 0 ? (v >>> k) : -((-v) >>> k);
    endfunction

    function automatic int floor_sqrt(int v);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    // atan2 in q12 radians through a vectoring rotation sequence
    function automatic int direction_q12(int gx, int gy);
        longint ax;
        longint ay;
        longint x;
        longint y;
        longint xs;
        longint ys;
        longint th;
        ax = gx < 0 ? -gx : gx;
        ay = gy < 0 ? -gy : gy;
        if (ay == 0) begin
            th = 0;
        end else if (ax == 0) begin
            th = 2 * arc_tab[0];
        end else begin
            x = ax << 40;
            y = ay << 40;
            th = 0;
            for (int k = 0; k < 48; k++) begin
                xs = shr_sym(x, k);
                ys = shr_sym(y, k);
                if (y >= 0) begin
                    x += ys; y -= xs; th += arc_tab[k];
                end else begin
                    x -= ys; y += xs; th -= arc_tab[k];
                end
            end
        end
        if (gx < 0) th = 4 * arc_tab[0] - th;
        th = (th + (longint'(1) << 43)) >>> 44;
        return gy < 0 ? -int'(th) : int'(th);
    endfunction

    function automatic void push_grad(int rr, int cc, int row, int col);
        int top;
        int bot;
        int lef;
        int rig;
        int gx;
        int gy;
        t_grad g;
        top = (row == 0) ? rr : rr - 1;
        bot = (rr == 2) ? 2 : rr + 1;
        lef = (col == 0) ? cc : cc - 1;
        rig = (cc == 2) ? 2 : cc + 1;
        gx = win[top][rig] + 2 * win[rr][rig] + win[bot][rig]
           - win[top][lef] - 2 * win[rr][lef] - win[bot][lef];
        gy = win[bot][lef] + 2 * win[bot][cc] + win[bot][rig]
           - win[top][lef] - 2 * win[top][cc] - win[top][rig];
        g.row = row[9:0];
        g.col = col[9:0];
        g.gx = gx[10:0];
        g.gy = gy[10:0];
        g.mag = 11'(floor_sqrt(gx * gx + gy * gy));
        g.ang = 15'(direction_q12(gx, gy));
        g.last = 1'b0;
        grad_q.insert(grad_q.size(), g);
    endfunction

    // advance the window by one pixel and queue the gradients it completes
    function automatic int predict_pixel(logic [7:0] px);
        int w;
        int h;
        int r;
        int c;
        int n;
        logic [7:0] up;
        logic [7:0] lo;
        w = width_reg < 2 ? 2 : (width_reg > MAXW ? MAXW : width_reg);
        h = height_reg < 2 ? 2 : (height_reg > MAXH ? MAXH : height_reg);
        r = row_pos;
        c = col_pos;
        n = 0;
        if (c >= w || r >= h) begin
            c = 0; r = 0;
        end
        up = store_up[c];
        lo = store_lo[c];
        store_up[c] = lo;
        store_lo[c] = px;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up;
        win[1][2] = lo;
        win[2][2] = px;
        if (r >= 1) begin
            if (c >= 1) begin push_grad(1, 1, r - 1, c - 1); n++; end
            if (c == w - 1) begin push_grad(1, 2, r - 1, c); n++; end
        end
        if (r == h - 1) begin
            if (c >= 1) begin push_grad(2, 1, r, c - 1); n++; end
            if (c == w - 1) begin push_grad(2, 2, r, c); n++; end
        end
        if (n > 0) grad_q[$].last = 1'b1;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        row_pos = r;
        col_pos = c;
        return n;
    endfunction

    function automatic void note_fail(string what, t_grad exp_g, t_grad got);
        if (fail_count < 10)
            $display("%s: expected r%0d c%0d gx%0d gy%0d m%0d a%0d l%0d, got r%0d c%0d gx%0d gy%0d m%0d a%0d l%0d",
                what, exp_g.row, exp_g.col, exp_g.gx, exp_g.gy, exp_g.mag, exp_g.ang,
                exp_g.last, got.row, got.col, got.gx, got.gy, got.mag, got.ang, got.last);
        fail_count++;
    endfunction

    // monitor: config writes, pixel transfers into the predictor, result checks
    always @(posedge i_clk) begin
        t_grad got;
        t_grad exp_g;
        t_pixel_row tr;
        int n;
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_wr_en) begin
                moved = 1'b1;
                if (i_cfg_index == CFG_FRAME_WIDTH) width_reg = i_cfg_data;
                else height_reg = i_cfg_data;
                row_pos = 0;
                col_pos = 0;
            end
            if (o_result_valid && !i_result_stall) begin
                moved = 1'b1;
                got = '{o_out_row, o_out_col, o_grad_x, o_grad_y, o_grad_magnitude,
                        o_grad_angle, o_last_of_run};
                if (grad_q.size() == 0) begin
                    note_fail("unexpected result", '0, got);
                end else begin
                    exp_g = grad_q.pop_front();
                    if (got !== exp_g) note_fail("result mismatch", exp_g, got);
                end
            end
            if (i_pixel_valid && !o_pixel_stall) begin
                moved = 1'b1;
                tr = typed_q.pop_front();
                n = predict_pixel(i_pixel_value);
                // typed-in gradients hold for every result of this pixel
                if (tr.known) begin
                    for (int k = grad_q.size() - n; k < grad_q.size(); k++) begin
                        exp_g = grad_q[k];
                        exp_g.gx = tr.gx[10:0];
                        exp_g.gy = tr.gy[10:0];
                        exp_g.mag = tr.mag[10:0];
                        exp_g.ang = tr.ang[14:0];
                        if (exp_g !== grad_q[k]) note_fail("predictor disagrees with table",
                                                           exp_g, grad_q[k]);
                    end
                end
            end
            idle_cycles <= moved ? 0 : idle_cycles + 1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (idle_cycles > WATCHDOG) begin
            $display("sobel_gradient_magnitude_angle: mismatch");
            $finish;
        end
    end

    // receiver: random stall, a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_result_stall = 1'b1;
            hold_left--;
        end else if (no_idle) begin
            i_result_stall = 1'b0;
        end else begin
            i_result_stall = ($urandom_range(0, 99) < STALL_PCT);
        end
    end

    task automatic write_reg(logic idx, logic [10:0] value);
        @(negedge i_clk);
        i_pixel_valid = 1'b0;
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic send_pixel(t_pixel_row tr);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 99) < STALL_PCT) begin
            i_pixel_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        typed_q.insert(typed_q.size(), tr);
        i_pixel_valid = 1'b1;
        i_pixel_value = tr.pix;
        forever begin
            @(posedge i_clk);
            if (!o_pixel_stall) break;
        end
    endtask

    // sender pauses until every gradient is out, then lets the block settle
    task automatic drain();
        @(negedge i_clk);
        i_pixel_valid = 1'b0;
        while (grad_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic t_pixel_row plain(logic [7:0] v);
        return '{v, 1'b0, 0, 0, 0, 0};
    endfunction

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    t_pixel_row frame_table[20] = '{
        // flat frame: no gradient at all
        '{8'd255, 1, 0, 0, 0, 0}, '{8'd255, 1, 0, 0, 0, 0},
        '{8'd255, 1, 0, 0, 0, 0}, '{8'd255, 1, 0, 0, 0, 0},
        // bright left column: strongest negative x sum, angle pi
        '{8'd255, 1, -1020, 0, 1020, 12868}, '{8'd0, 1, -1020, 0, 1020, 12868},
        '{8'd255, 1, -1020, 0, 1020, 12868}, '{8'd0, 1, -1020, 0, 1020, 12868},
        // bright bottom row: strongest positive y sum, angle pi/2
        '{8'd0, 1, 0, 1020, 1020, 6434}, '{8'd0, 1, 0, 1020, 1020, 6434},
        '{8'd255, 1, 0, 1020, 1020, 6434}, '{8'd255, 1, 0, 1020, 1020, 6434},
        // diagonal, alternating-bit and single-bit patterns
        '{8'd0, 0, 0, 0, 0, 0}, '{8'd255, 0, 0, 0, 0, 0},
        '{8'd255, 0, 0, 0, 0, 0}, '{8'd0, 0, 0, 0, 0, 0},
        '{8'd170, 0, 0, 0, 0, 0}, '{8'd85, 0, 0, 0, 0, 0},
        '{8'd1, 0, 0, 0, 0, 0}, '{8'd128, 0, 0, 0, 0, 0}
    };

    initial begin
        int sent;
        int phase;
        int w;
        int h;
        int count;
        arc_tab[0] = 4 * arc_recip(5) - arc_recip(239);
        for (int k = 1; k < 48; k++) arc_tab[k] = arc_pow2(k);
        for (int k = 0; k < MAXW; k++) begin
            store_up[k] = '0;
            store_lo[k] = '0;
        end
        for (int k = 0; k < 9; k++) win[k / 3][k % 3] = '0;
        row_pos = 0;
        col_pos = 0;
        width_reg = FRAME_WIDTH_RESET;
        height_reg = FRAME_HEIGHT_RESET;

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // a few pixels at the reset frame size, first row yields nothing
        for (int k = 0; k < 3; k++) send_pixel(plain(rand_pixel()));
        drain();
        // width below range clamps to two
        write_reg(CFG_FRAME_WIDTH, 11'd1);
        write_reg(CFG_FRAME_HEIGHT, 11'd2);
        foreach (frame_table[k]) send_pixel(frame_table[k]);
        drain();

        // random frames, mostly small, with clamped extremes mixed in
        sent = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS) begin
            case (phase)
                0: begin w = 0; h = 0; end
                1: begin w = 2047; h = 2; end
                3: begin w = 2; h = 1024; end
                default: begin w = $urandom_range(2, 10); h = $urandom_range(2, 6); end
            endcase
            if (phase < 2 || phase == 3 || $urandom_range(0, 2) != 0) begin
                write_reg(CFG_FRAME_WIDTH, w[10:0]);
                write_reg(CFG_FRAME_HEIGHT, h[10:0]);
            end else begin
                // a single write also restarts the frame
                write_reg(CFG_FRAME_HEIGHT, h[10:0]);
            end
            if (phase == 1) count = 12;
            else if (phase == 3) count = 10;
            else count = $urandom_range(1, (w < 2 ? 2 : w) * (h < 2 ? 2 : h) + 4);
            if (count > 40) count = 40;
            // one phase holds the output back so the block fills up
            if (phase == 2) begin
                count = 30;
                hold_left = 400;
            end
            no_idle = (phase == 4);
            for (int k = 0; k < count; k++) send_pixel(plain(rand_pixel()));
            sent += count;
            drain();
            no_idle = 0;
            phase++;
        end

        if (fail_count == 0) begin
            $display("sobel_gradient_magnitude_angle: match");
        end else begin
            $display("sobel_gradient_magnitude_angle: mismatch");
        end
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/sgma_pkg.sv
rtl/sgma_ram.sv
rtl/sgma_datapath.sv
rtl/sgma_ctrl.sv
rtl/sobel_gradient_magnitude_angle.sv
rtl/sgma_checker.sv
test/tb_sobel_gradient_magnitude_angle.sv
